[rtl/sdi_pkg.sv]
// shared types and constants for the spring damper integrator
// used by sdi_seq and spring_damper_integrate
package sdi_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_REST_LENGTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_STIFFNESS    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DAMPING      = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_INVERSE_MASS = 2'd3;

  localparam logic [30:0] REST_LENGTH_RST  = 31'd65536;
  localparam logic [30:0] STIFFNESS_RST    = 31'd65536;
  localparam logic [30:0] DAMPING_RST      = 31'd0;
  localparam logic [30:0] INVERSE_MASS_RST = 31'd65536;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    logic [30:0] rest_length;
    logic [30:0] stiffness;
    logic [30:0] damping;
    logic [30:0] inverse_mass;
  } cfg_t;

  typedef struct packed {
    q_t          tx;
    q_t          ty;
    q_t          tz;
    logic [16:0] dt;
  } req_t;

  typedef struct packed {
    q_t px;
    q_t py;
    q_t pz;
    q_t vx;
    q_t vy;
    q_t vz;
  } res_t;

  function automatic q_t sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

[rtl/spring_damper_integrate.sv]
// Spring damper integrator. One request carries a target point and a time
// step; the block answers with the new position and velocity, computed
// with a 33-step square root and three 64-step divisions (none when the
// point sits exactly on its target) through one shared bit-serial unit,
// plus the shared multiplier. It takes no request while working or while a
// result waits; the result register holds until taken, so a new request is
// not taken before the last result has been taken. Depends on sdi_pkg and
// sdi_seq.
module spring_damper_integrate import sdi_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,   // target_x, target_y, target_z, time_step
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // pos x, y, z, vel x, y, z
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data
);

  cfg_t cfg_r;
  req_t req;
  res_t res;
  logic busy, done, start;
  logic out_valid_r;
  logic [191:0] out_data_r;

  assign req = '{tx: in_tdata[31:0], ty: in_tdata[63:32], tz: in_tdata[95:64],
                 dt: in_tdata[112:96]};
  assign in_tready = !busy && !out_valid_r && !done;
  assign start = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{rest_length: REST_LENGTH_RST, stiffness: STIFFNESS_RST,
                 damping: DAMPING_RST, inverse_mass: INVERSE_MASS_RST};
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_REST_LENGTH:  cfg_r.rest_length  <= cfg_data;
          REG_STIFFNESS:    cfg_r.stiffness    <= cfg_data;
          REG_DAMPING:      cfg_r.damping      <= cfg_data;
          REG_INVERSE_MASS: cfg_r.inverse_mass <= cfg_data;
          default: ;
        endcase
      end
      if (done) begin
        out_valid_r <= 1'b1;
        out_data_r <= {res.vz, res.vy, res.vx, res.pz, res.py, res.px};
      end else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  sdi_seq #(.FRAC_BITS(FRAC_BITS)) u_seq (
    .clk, .rst_n, .start, .req, .cfg(cfg_r), .busy, .done, .res
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/sdi_seq.sv]
// sequencer for one spring step: one shared 32x32 multiplier and one shared
// 1-bit-per-cycle root/divide unit, used in turn; depends on sdi_pkg
module sdi_seq import sdi_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  req_t req,
  input  cfg_t cfg,
  output logic busy,
  output logic done,
  output res_t res
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SQ, S_ROOT, S_DIVSET, S_DIV, S_TEN, S_FS, S_FD, S_ACC,
    S_DV, S_DP, S_NEXT
  } state_t;

  state_t state_r;
  logic [1:0] ax_r;
  logic [6:0] cnt_r;
  q_t p_r [3];
  q_t v_r [3];
  q_t d_r [3];
  q_t u_r [3];
  q_t t_r [3];
  logic [16:0] dt_r;
  logic [65:0] sum_r;
  logic [65:0] rem_r;
  logic [32:0] root_r;
  q_t tension_r;
  q_t fs_r;
  q_t f_r;
  logic [63:0] dnum_r;
  logic [63:0] quo_r;

  // shared multiplier operands
  logic signed [32:0] ma, mb;
  logic [63:0] mprod;
  logic        mneg;
  logic signed [65:0] mulq;
  logic [31:0] mag_a, mag_b;
  logic [64:0] div_sh;

  function automatic logic [31:0] mag_d(input q_t a);
    return a[31] ? 32'(-a) : a;
  endfunction

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_SQ:  begin ma = 33'(d_r[ax_r]); mb = 33'(d_r[ax_r]); end
      S_TEN: begin ma = {2'b00, cfg.stiffness};
                   mb = $signed({1'b0, root_r[31:0]}) - $signed({2'b00, cfg.rest_length}); end
      S_FS:  begin ma = 33'(tension_r); mb = 33'(u_r[ax_r]); end
      S_FD:  begin ma = {2'b00, cfg.damping}; mb = 33'(v_r[ax_r]); end
      S_ACC: begin ma = 33'(f_r); mb = {2'b00, cfg.inverse_mass}; end
      S_DV:  begin ma = 33'(f_r); mb = {16'd0, dt_r}; end
      S_DP:  begin ma = 33'(v_r[ax_r]); mb = {16'd0, dt_r}; end
      default: ;
    endcase
    mag_a = ma[32] ? 32'(-ma) : ma[31:0];
    mag_b = mb[32] ? 32'(-mb) : mb[31:0];
    mneg  = ma[32] ^ mb[32];
    mprod = mag_a * mag_b;
    mulq  = mneg ? -$signed({2'b00, mprod >> FRAC_BITS})
                 : $signed({2'b00, mprod >> FRAC_BITS});
    div_sh = {rem_r[63:0], dnum_r[63]};
  end

  // restoring root: two bits of radicand per cycle into rem, one root bit out
  logic [67:0] rt_rem;
  logic [67:0] rt_trial;
  assign rt_rem   = {rem_r, sum_r[65:64]};
  assign rt_trial = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        p_r[i] <= '0;
        v_r[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state_r)
        S_IDLE: if (start) begin
          t_r[0] <= req.tx; t_r[1] <= req.ty; t_r[2] <= req.tz;
          dt_r <= req.dt;
          ax_r <= 2'd0;
          sum_r <= '0;
          state_r <= S_DISP;
        end
        S_DISP: begin
          for (int i = 0; i < 3; i++)
            d_r[i] <= sat32(66'(p_r[i]) - 66'(t_r[i]));
          state_r <= S_SQ;
        end
        S_SQ: begin
          sum_r <= sum_r + 66'(mprod);
          if (ax_r == 2'd2) begin
            ax_r <= 2'd0;
            rem_r <= '0;
            root_r <= '0;
            cnt_r <= 7'd33;
            state_r <= S_ROOT;
          end else ax_r <= ax_r + 2'd1;
        end
        S_ROOT: begin
          sum_r <= sum_r << 2;
          if (rt_rem >= rt_trial) begin
            rem_r  <= 66'(rt_rem - rt_trial);
            root_r <= {root_r[31:0], 1'b1};
          end else begin
            rem_r  <= 66'(rt_rem);
            root_r <= {root_r[31:0], 1'b0};
          end
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) state_r <= S_DIVSET;
        end
        S_DIVSET: begin
          if (root_r == '0) begin
            u_r[ax_r] <= '0;
            state_r <= S_NEXT;
          end else begin
            dnum_r <= 64'({mag_d(d_r[ax_r]), FRAC_BITS'(0)});
            rem_r <= '0;
            quo_r <= '0;
            cnt_r <= 7'd64;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          dnum_r <= dnum_r << 1;
          if (66'(div_sh) >= 66'(root_r)) begin
            rem_r <= 66'(div_sh) - 66'(root_r);
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= 66'(div_sh);
            quo_r <= {quo_r[62:0], 1'b0};
          end
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) state_r <= S_NEXT;
        end
        S_NEXT: begin
          if (root_r != '0)
            u_r[ax_r] <= d_r[ax_r][31] ? 32'(-quo_r) : quo_r[31:0];
          if (ax_r == 2'd2) begin
            ax_r <= 2'd0;
            state_r <= S_TEN;
          end else begin
            ax_r <= ax_r + 2'd1;
            state_r <= S_DIVSET;
          end
        end
        S_TEN: begin
          tension_r <= sat32(mulq);
          state_r <= S_FS;
        end
        S_FS: begin
          fs_r <= sat32(-66'(sat32(mulq)));
          state_r <= S_FD;
        end
        S_FD: begin
          f_r <= sat32(66'(fs_r) + 66'(sat32(-66'(sat32(mulq)))));
          state_r <= S_ACC;
        end
        S_ACC: begin
          f_r <= sat32(mulq);
          state_r <= S_DV;
        end
        S_DV: begin
          v_r[ax_r] <= sat32(66'(v_r[ax_r]) + 66'(sat32(mulq)));
          state_r <= S_DP;
        end
        S_DP: begin
          p_r[ax_r] <= sat32(66'(p_r[ax_r]) + 66'(sat32(mulq)));
          if (ax_r == 2'd2) begin
            done <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            ax_r <= ax_r + 2'd1;
            state_r <= S_FS;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign res  = '{px: p_r[0], py: p_r[1], pz: p_r[2],
                  vx: v_r[0], vy: v_r[1], vz: v_r[2]};

endmodule

[rtl/sdi_check.sv]
// port-level checks for spring_damper_integrate, bound to the top level
// depends on nothing beyond the top level's ports
module sdi_check (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready
);
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("request taken while result pending");
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("ready after request");
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid) else $error("result too early");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");
endmodule

bind spring_damper_integrate sdi_check u_sdi_check (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready
);

[tb/spring_damper_integrate_test.sv]
// testbench for spring_damper_integrate: drives target/time-step requests,
// predicts position and velocity in a local fixed-point model, checks each result
// depends on sdi_pkg and the spring_damper_integrate rtl
module spring_damper_integrate_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sdi_pkg::*;

  localparam int unsigned FB = 16;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [191:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [30:0]  cfg_data;

  spring_damper_integrate dut (.*);

  longint spring_rest, spring_k, damp_k, inv_mass;
  longint pos_st[3], vel_st[3];
  res_t   expected_states[$];
  int     mismatches;
  bit     failed;
  int     stall_mode;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint clamp32(input longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint fix_mul(input longint a, input longint b);
    bit neg;
    longint unsigned r;
    longint unsigned ma, mb;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    r = (ma * mb) >> FB;
    return clamp32(neg ? -longint'(r) : longint'(r));
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic res_t step_point(input req_t rq);
    longint d[3], u[3], tension, fs, fd, f, a, dt;
    longint unsigned sumsq, len, md, q;
    res_t r;
    q_t tgt[3];
    tgt[0] = rq.tx;
    tgt[1] = rq.ty;
    tgt[2] = rq.tz;
    dt = longint'(rq.dt);
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = clamp32(pos_st[i] - longint'(tgt[i]));
      md = (d[i] < 0) ? -d[i] : d[i];
      sumsq += md * md;
    end
    len = int_sqrt(sumsq);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        u[i] = 0;
      end else begin
        md = (d[i] < 0) ? -d[i] : d[i];
        q = (md << FB) / len;
        u[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
    tension = fix_mul(spring_k, longint'(len) - spring_rest);
    for (int i = 0; i < 3; i++) begin
      fs = clamp32(-fix_mul(tension, u[i]));
      fd = clamp32(-fix_mul(damp_k, vel_st[i]));
      f = clamp32(fs + fd);
      a = fix_mul(f, inv_mass);
      vel_st[i] = clamp32(vel_st[i] + fix_mul(a, dt));
      pos_st[i] = clamp32(pos_st[i] + fix_mul(vel_st[i], dt));
    end
    r.px = pos_st[0][31:0];
    r.py = pos_st[1][31:0];
    r.pz = pos_st[2][31:0];
    r.vx = vel_st[0][31:0];
    r.vy = vel_st[1][31:0];
    r.vz = vel_st[2][31:0];
    return r;
  endfunction

  task automatic send_request(input q_t tx, input q_t ty, input q_t tz, input logic [16:0] dt);
    req_t rq;
    rq.tx = tx;
    rq.ty = ty;
    rq.tz = tz;
    rq.dt = dt;
    in_tdata <= {7'b0, dt, tz, ty, tx};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_states.push_back(step_point(rq));
    @(negedge clk);
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_random(input int n, input bit near);
    int burst;
    q_t t[3];
    logic [16:0] dt;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (near) t[i] = $urandom_range(0, 9) == 0 ? q_t'($urandom)
                         : q_t'($signed($urandom_range(0, 20 << FB)) - (10 << FB));
        else t[i] = q_t'($urandom);
      end
      case ($urandom_range(0, 5))
        0: dt = 17'd65536;
        1: dt = 17'($urandom);
        default: dt = 17'($urandom_range(0, 8192));
      endcase
      send_request(t[0], t[1], t[2], dt);
      if (burst <= 0) begin
        burst = $urandom_range(1, 12);
        repeat ($urandom_range(0, 20)) @(negedge clk);
      end
      burst--;
    end
  endtask

  task automatic drain_results();
    while (expected_states.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_REST_LENGTH:  spring_rest = val;
      REG_STIFFNESS:    spring_k = val;
      REG_DAMPING:      damp_k = val;
      REG_INVERSE_MASS: inv_mass = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [30:0] r, input logic [30:0] k,
                          input logic [30:0] dmp, input logic [30:0] im);
    drain_results();
    write_reg(REG_REST_LENGTH, r);
    write_reg(REG_STIFFNESS, k);
    write_reg(REG_DAMPING, dmp);
    write_reg(REG_INVERSE_MASS, im);
  endtask

  task automatic test_directed();
    send_request(0, 0, 0, 17'd0);
    send_request(0, 0, 0, 17'd65536);
    send_request(32'sh00010000, 0, 0, 17'd6554);
    send_request(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 17'd65536);
    send_request(32'sh80000000, 32'sh80000000, 32'sh80000000, 17'd65536);
    send_request(32'sh80000000, 32'sh7fffffff, 0, 17'h1ffff);
    send_request(-32'sd65536, 32'sd131072, -32'sd196608, 17'd1000);
    send_request(32'shffffffff, 32'sh00000001, 32'sh55555555, 17'h1ffff);
    send_request(32'shaaaaaaaa, 32'sh55555555, 32'shffffffff, 17'd1);
  endtask

  task automatic test_damped_config();
    set_regs(31'd0, 31'd262144, 31'd32768, 31'd32768);
    send_random(150, 1'b1);
  endtask

  task automatic test_extreme_config();
    set_regs(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
    send_random(60, 1'b0);
    set_regs(31'd0, 31'd0, 31'd0, 31'd0);
    send_random(30, 1'b0);
  endtask

  task automatic test_random_config();
    for (int p = 0; p < 6; p++) begin
      set_regs(31'($urandom_range(0, 8 << FB)), 31'($urandom),
               31'($urandom_range(0, 2 << FB)), 31'($urandom_range(0, 4 << FB)));
      send_random(75, p[0]);
    end
  endtask

  always @(negedge clk) begin
    stall_mode <= stall_mode + 1;
    if (stall_mode[8]) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    res_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
             out_tdata[127:96], out_tdata[159:128], out_tdata[191:160]};
      if (expected_states.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        exp_r = expected_states.pop_front();
        if (got !== exp_r) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch pos exp %h %h %h got %h %h %h vel exp %h %h %h got %h %h %h",
                     exp_r.px, exp_r.py, exp_r.pz, got.px, got.py, got.pz,
                     exp_r.vx, exp_r.vy, exp_r.vz, got.vx, got.vy, got.vz);
        end
      end
    end
  end

  initial begin
    #(50ms);
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    failed = 1'b0;
    spring_rest = REST_LENGTH_RST;
    spring_k = STIFFNESS_RST;
    damp_k = DAMPING_RST;
    inv_mass = INVERSE_MASS_RST;
    for (int i = 0; i < 3; i++) begin
      pos_st[i] = 0;
      vel_st[i] = 0;
    end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_damped_config();
    test_extreme_config();
    test_random_config();
    drain_results();
    if (!failed && expected_states.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
